>>> rtl/dpr_pkg.sv
package dpr_pkg;

  localparam int unsigned LIMIT_W = 11;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_PAYLOAD_LIMIT = 3'd0;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_ABANDON  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         payload_byte;
    logic [LIMIT_W-1:0] payload_length;
    logic [7:0]         reply_char;
    logic [7:0]         received_checksum;
    logic [7:0]         computed_checksum;
  } res_t;

  // Hex digit decode; anything that is not 0-9, a-f or A-F reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

>>> rtl/dpr_cfg_regs.sv
module dpr_cfg_regs
  import dpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output logic [LIMIT_W-1:0] payload_limit
);

  logic [LIMIT_W-1:0] payload_limit_r;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_limit_r <= LIMIT_RESET;
    end else if (wr_en && cfg_paddr == ADDR_PAYLOAD_LIMIT) begin
      payload_limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr == ADDR_PAYLOAD_LIMIT) begin
      cfg_prdata = {{(32-LIMIT_W){1'b0}}, payload_limit_r};
    end
  end

  assign payload_limit = payload_limit_r;

endmodule

>>> rtl/dpr_framer.sv
module dpr_framer
  import dpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic [LIMIT_W-1:0] payload_limit,
  input  logic               out_free,
  output logic               res_valid,
  output res_t               res
);

  // The limit register is 11 bits, so a capacity beyond its range never bites.
  localparam logic [LIMIT_W-1:0] CAP_SAT =
    (PAYLOAD_CAPACITY > 2047) ? 11'd2047 : LIMIT_W'(PAYLOAD_CAPACITY);

  logic               in_valid_r;
  logic [7:0]         char_r;
  logic               fire;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [LIMIT_W-1:0] count_r, count_nxt;
  logic [3:0]         nib_r, nib_nxt;

  logic [LIMIT_W-1:0] eff_limit;
  logic [7:0]         rx_sum;
  logic [7:0]         sum_add;

  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= 8'd0;
      count_r <= '0;
      nib_r   <= 4'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      nib_r   <= nib_nxt;
    end
  end

  assign eff_limit = (payload_limit > CAP_SAT) ? CAP_SAT : payload_limit;
  assign rx_sum    = {nib_r, hex_value(char_r)};
  assign sum_add   = sum_r + char_r;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    nib_nxt   = nib_r;
    res_valid = 1'b0;
    res.kind              = KIND_PAYLOAD;
    res.payload_byte      = 8'd0;
    res.payload_length    = count_r;
    res.reply_char        = 8'd0;
    res.received_checksum = 8'd0;
    res.computed_checksum = sum_r;
    case (phase_r)
      PH_HUNT: begin
        if (char_r == CH_START) begin
          phase_nxt = PH_DATA;
          sum_nxt   = 8'd0;
          count_nxt = '0;
        end
      end
      PH_DATA: begin
        if (char_r == CH_END) begin
          phase_nxt = PH_HEX1;
        end else if (char_r == CH_START) begin
          // Restart: report the old packet as abandoned, then clear.
          res_valid = fire;
          res.kind  = KIND_ABANDON;
          sum_nxt   = 8'd0;
          count_nxt = '0;
        end else if (count_r >= eff_limit) begin
          res_valid = fire;
          res.kind  = KIND_ABANDON;
          phase_nxt = PH_HUNT;
        end else begin
          sum_nxt   = sum_add;
          count_nxt = count_r + 1'b1;
          res_valid = fire;
          res.payload_byte      = char_r;
          res.payload_length    = count_r + 1'b1;
          res.computed_checksum = sum_add;
        end
      end
      PH_HEX1: begin
        nib_nxt   = hex_value(char_r);
        phase_nxt = PH_HEX2;
      end
      PH_HEX2: begin
        res_valid = fire;
        res.received_checksum = rx_sum;
        if (rx_sum == sum_r) begin
          res.kind       = KIND_ACCEPT;
          res.reply_char = CH_ACK;
        end else begin
          res.kind       = KIND_MISMATCH;
          res.reply_char = CH_NAK;
        end
        if (char_r == CH_START) begin
          phase_nxt = PH_DATA;
          sum_nxt   = 8'd0;
          count_nxt = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == PH_HUNT) |-> !res_valid)
    else $error("result produced while hunting for start");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_PAYLOAD) |=> (count_r == $past(count_r) + 1'b1))
    else $error("payload byte did not advance the count");

  a_hex2_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == PH_HEX2) |=> (phase_r == PH_HUNT || phase_r == PH_DATA))
    else $error("checksum phase did not finish the packet");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_free) |=> (in_valid_r && $stable(char_r)))
    else $error("pending character lost while result stalled");

endmodule

>>> rtl/debug_packet_receiver_core.sv
// Debug packet receiver core: character framing for "$<payload>#hh" packets.
// Received characters arrive as transfers on the in_ stream, one character in
// in_tdata. Each character yields zero or one result on the out_ stream:
// a forwarded payload byte, an accept ('+' in reply_char), a checksum
// mismatch ('-'), or an abandoned packet; out_tuser carries the kind.
// The payload limit is set through the APB-style cfg_ port at address 0 and
// must only be written while no character is in flight.
// Throughput is one character per cycle while out_tready is held high. A
// character is captured in an input register, decoded by the phase machine,
// and its result is captured in and presented from the output register.
// Characters that produce no result advance the phase machine from the input
// register and leave the output register untouched.
// When the receiver holds out_tready low, the output register keeps its
// result, one more character is held in the input register, and then
// in_tready drops until the output register drains.
// Reset (synchronous, active low) returns to hunting for '$', clears the
// running sum and count, empties both registers, and sets the limit to 1024.
module debug_packet_receiver_core
  import dpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] payload_byte, [18:8] payload_length,
                                   // [26:19] reply_char, [34:27] received_checksum,
                                   // [42:35] computed_checksum, [47:43] zero
  output logic [1:0]  out_tuser,   // [1:0] kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [LIMIT_W-1:0] payload_limit;
  logic               out_free;
  logic               res_valid;
  res_t               res;
  logic               out_valid_r;
  res_t               out_r;

  dpr_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .payload_limit (payload_limit)
  );

  dpr_framer #(
    .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
  ) u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .payload_limit (payload_limit),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  // The output register is free when empty or when its result leaves now.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {5'd0, out_r.computed_checksum, out_r.received_checksum,
                       out_r.reply_char, out_r.payload_length, out_r.payload_byte};

endmodule
